[rtl/core/brct_pkg.sv]
// shared constants and types of the byte range coverage tracker
package brct_pkg;

   localparam int MAX_RANGES  = 16;
   localparam int OFFSET_BITS = 48;

   localparam int START_W = 48;
   localparam int LEN_W   = 31;
   localparam int FSIZE_W = 48;
   localparam int COV_W   = 49;
   localparam int HELD_W  = 5;

   // start + length - 1 of the widest item
   localparam int SPAN_W = 49;

   localparam int IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int RCNT_W = $clog2(MAX_RANGES + 1);
   localparam int ADDR_W = $clog2(2 * MAX_RANGES);
   localparam int SUM_W  = OFFSET_BITS + 1;
   localparam int CMP_W  = (SUM_W > FSIZE_W) ? SUM_W : FSIZE_W;

   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [START_W-1:0] range_start;
      logic [LEN_W-1:0]   range_length;
   } req_type;

   typedef struct packed {
      logic [COV_W-1:0]  covered_bytes;
      logic              is_complete;
      logic              just_completed;
      logic [HELD_W-1:0] ranges_held;
      logic              dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_DROP,
      CMD_MERGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [OFFSET_BITS-1:0] lo;
      logic [OFFSET_BITS-1:0] hi;
   } cmd_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] s;
      logic [OFFSET_BITS-1:0] e;
   } entry_type;

   // handshake between the queue and its consumer
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_out_type;

endpackage

[rtl/core/brct_front.sv]
// front end: accepts items and classifies them into queue commands
module brct_front
   import brct_pkg::*;
(
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push_valid,
   output cmd_type push_cmd
);

   logic [SPAN_W-1:0] hi_wide;
   logic              over;

   assign req_ready  = !queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      hi_wide = SPAN_W'(req_data.range_start) + SPAN_W'(req_data.range_length)
                - SPAN_W'(1);
      if (OFFSET_BITS < SPAN_W) begin
         over = (hi_wide >> OFFSET_BITS) != '0;
      end else begin
         over = 1'b0;
      end

      push_cmd.lo = OFFSET_BITS'(req_data.range_start);
      push_cmd.hi = OFFSET_BITS'(hi_wide);
      priority if (req_data.range_length == '0) begin
         push_cmd.kind = CMD_NOP;
      end else if (over) begin
         push_cmd.kind = CMD_DROP;
      end else begin
         push_cmd.kind = CMD_MERGE;
      end
   end

endmodule

[rtl/core/brct_queue.sv]
// short command queue between front end and merge engine
module brct_queue
   import brct_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  cmd_type   push_cmd,
   output logic      full,
   input  logic      pop,
   output q_out_type q_out
);

   cmd_type           slot_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wptr_ff;
   logic [QPTR_W-1:0] rptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_pop;

   assign full        = cnt_ff == QCNT_W'(Q_DEPTH);
   assign q_out.valid = cnt_ff != '0;
   assign q_out.cmd   = slot_ff[rptr_ff];
   assign do_pop      = pop && q_out.valid;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push_valid) begin
            wptr_ff <= (wptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
         end
         if (push_valid && !do_pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (do_pop && !push_valid) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

endmodule

[rtl/core/brct_back.sv]
// merge engine: range table, coverage sum, completion and result register
module brct_back
   import brct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [FSIZE_W-1:0] file_size,
   input  q_out_type          q_out,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_FINISH,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic                   bank_ff;
   logic [RCNT_W-1:0]      count_ff;
   logic [SUM_W-1:0]       covered_ff;
   logic                   done_ff;
   logic [RCNT_W-1:0]      i_ff;
   logic [RCNT_W-1:0]      n_ff;
   logic                   placed_ff;
   logic                   ovf_ff;
   logic                   drop_ff;
   logic [OFFSET_BITS-1:0] lo_ff;
   logic [OFFSET_BITS-1:0] hi_ff;
   logic [SUM_W-1:0]       sum_ff;
   entry_type              rd_entry_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   // two banks: read the live table, write the merged one into the other
   entry_type mem [2 * MAX_RANGES];

   logic [OFFSET_BITS:0] b_plus;
   logic [OFFSET_BITS:0] hi_plus;
   logic                 gap_left;
   logic                 gap_right;
   logic [RCNT_W-1:0]    i_next;
   logic                 last;
   logic                 wr_req;
   logic                 wr_room;
   entry_type            wr_entry;
   logic                 adv;
   logic                 place_now;
   logic                 merge_now;
   logic                 rd_req;
   logic [RCNT_W-1:0]    rd_idx;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [OFFSET_BITS:0] seg_len;
   logic [SUM_W-1:0]     sum_add;
   logic                 reach;
   logic                 out_free;
   logic                 start_merge;
   logic                 rsp_load;

   function automatic rsp_type make_rsp(logic [SUM_W-1:0] cov, logic comp, logic just,
                                        logic [RCNT_W-1:0] held, logic drop);
      rsp_type r;
      r.covered_bytes  = COV_W'(cov);
      r.is_complete    = comp;
      r.just_completed = just;
      r.ranges_held    = HELD_W'(held);
      r.dropped        = drop;
      return r;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_out.valid;
   assign rsp_load  = (state_ff == ST_COMMIT || state_ff == ST_EMIT) && out_free;

   assign start_merge = q_out.cmd.kind == CMD_MERGE && !done_ff;

   always_comb begin
      b_plus    = {1'b0, rd_entry_ff.e} + (OFFSET_BITS + 1)'(1);
      hi_plus   = {1'b0, hi_ff} + (OFFSET_BITS + 1)'(1);
      gap_left  = b_plus < {1'b0, lo_ff};
      gap_right = hi_plus < {1'b0, rd_entry_ff.s};
      i_next    = i_ff + RCNT_W'(1);
      last      = i_next == count_ff;

      wr_req    = 1'b0;
      wr_entry  = rd_entry_ff;
      adv       = 1'b0;
      place_now = 1'b0;
      merge_now = 1'b0;
      rd_req    = 1'b0;
      rd_idx    = i_next;

      unique case (state_ff)
         ST_IDLE: begin
            // prime the first table read while the command is taken
            rd_idx = '0;
            rd_req = q_out.valid && start_merge && count_ff != '0;
         end
         ST_MERGE: begin
            priority if (gap_left) begin
               wr_req = 1'b1;
               adv    = 1'b1;
            end else if (gap_right) begin
               wr_req = 1'b1;
               if (!placed_ff) begin
                  wr_entry  = '{s: lo_ff, e: hi_ff};
                  place_now = 1'b1;
               end else begin
                  adv = 1'b1;
               end
            end else begin
               merge_now = 1'b1;
               adv       = 1'b1;
            end
            rd_req = adv && !last;
         end
         ST_FINISH: begin
            wr_req   = !placed_ff;
            wr_entry = '{s: lo_ff, e: hi_ff};
         end
         default: begin
         end
      endcase

      wr_room = n_ff < RCNT_W'(MAX_RANGES);
      rd_addr = ADDR_W'(rd_idx[IDX_W-1:0]) + (bank_ff ? ADDR_W'(MAX_RANGES) : '0);
      wr_addr = ADDR_W'(n_ff[IDX_W-1:0]) + (!bank_ff ? ADDR_W'(MAX_RANGES) : '0);
      seg_len = {1'b0, wr_entry.e} - {1'b0, wr_entry.s} + (OFFSET_BITS + 1)'(1);
      sum_add = sum_ff + SUM_W'(seg_len);
      reach   = CMP_W'(sum_ff) >= CMP_W'(file_size);
   end

   always_ff @(posedge clock) begin
      if (wr_req && wr_room) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_req) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         covered_ff   <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_req) begin
            if (wr_room) begin
               n_ff   <= n_ff + RCNT_W'(1);
               sum_ff <= sum_add;
            end else begin
               ovf_ff <= 1'b1;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (q_out.valid) begin
                  lo_ff     <= q_out.cmd.lo;
                  hi_ff     <= q_out.cmd.hi;
                  i_ff      <= '0;
                  n_ff      <= '0;
                  placed_ff <= 1'b0;
                  ovf_ff    <= 1'b0;
                  sum_ff    <= '0;
                  drop_ff   <= q_out.cmd.kind == CMD_DROP && !done_ff;
                  if (start_merge) begin
                     state_ff <= (count_ff == '0) ? ST_FINISH : ST_MERGE;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_MERGE: begin
               if (place_now) begin
                  placed_ff <= 1'b1;
               end
               if (merge_now) begin
                  if (rd_entry_ff.s < lo_ff) begin
                     lo_ff <= rd_entry_ff.s;
                  end
                  if (rd_entry_ff.e > hi_ff) begin
                     hi_ff <= rd_entry_ff.e;
                  end
               end
               if (adv) begin
                  i_ff <= i_next;
                  if (last) begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (ovf_ff) begin
                     rsp_data_ff <= make_rsp(covered_ff, done_ff, 1'b0, count_ff, 1'b1);
                  end else begin
                     bank_ff     <= !bank_ff;
                     count_ff    <= n_ff;
                     covered_ff  <= sum_ff;
                     done_ff     <= reach;
                     rsp_data_ff <= make_rsp(sum_ff, reach, reach, n_ff, 1'b0);
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  rsp_data_ff  <= make_rsp(covered_ff, done_ff, 1'b0, count_ff, drop_ff);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RCNT_W'(MAX_RANGES))
      else $error("range count above table capacity");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> i_ff < count_ff)
      else $error("scan index past stored ranges");

   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> n_ff <= i_ff + RCNT_W'(placed_ff))
      else $error("merged table ahead of scan");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("complete flag cleared");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.dropped && rsp_data_ff.just_completed))
      else $error("dropped item marked as completing");
`endif

endmodule

[rtl/core/byte_range_coverage_tracker_top.sv]
// top level of the byte range coverage tracker
//
// tracks which bytes of one file have arrived: each item carries a start offset and
// a length, and the block keeps up to MAX_RANGES sorted, disjoint inclusive ranges,
// merging every item with all stored ranges it overlaps or touches. each item gives
// one result with the covered byte total, the range count, a sticky complete flag
// (covered total at or above file_size), a flag on the item that completed the file,
// and a drop flag for items that run past the offset width or would overflow the
// table. zero-length items and items after completion report state unchanged.
// the front end classifies items and pushes them into a two-item queue, so the
// input keeps flowing while the merge engine works. a merging item is scanned
// against the table, one stored range per cycle through its single registered
// read port; the scan holds on a stored range while the new range is written in
// below it without touching it. zero-length, dropped and post-completion items
// skip the scan. a finished result waits in an output register while the engine
// starts the next item. the table needs no clearing after reset; file_size must be
// written through the csr port while the block is idle, which the block itself
// does not enforce; it is checked only when an item is merged
module byte_range_coverage_tracker_top
   import brct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [FSIZE_W-1:0] csr_wr_data
);

   // file size register
   logic [FSIZE_W-1:0] file_size_ff;

   // front end to queue
   logic      queue_full;
   logic      push_valid;
   cmd_type   push_cmd;

   // queue to merge engine
   q_out_type q_out;
   logic      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
      end else if (csr_wr_en) begin
         file_size_ff <= csr_wr_data;
      end
   end

   // classify: no change, out of range, or merge
   brct_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // decouples item intake from the table scan
   brct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (q_pop),
      .q_out      (q_out)
   );

   // table merge, coverage sum and result register
   brct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .file_size  (file_size_ff),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/testbench.sv]
// self-checking testbench for the byte range coverage tracker
module testbench;
   import brct_pkg::*;

   // clock, reset and the block's ports, all at known values from time zero
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_type            req_data    = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [FSIZE_W-1:0] csr_wr_data = '0;

   // predicted state of the tracker: the sorted disjoint range table and its totals
   logic [OFFSET_BITS-1:0] span_lo [MAX_RANGES];
   logic [OFFSET_BITS-1:0] span_hi [MAX_RANGES];
   int                     span_count      = 0;
   logic [COV_W-1:0]       bytes_covered   = '0;
   bit                     file_done       = 1'b0;
   logic [FSIZE_W-1:0]     file_size_model = '0;

   // items waiting to be offered, and results waiting to be seen
   req_type delivery_queue [$];
   rsp_type expected_status [$];
   rsp_type want;

   int queued_total   = 0;
   int accepted_total = 0;
   int results_seen   = 0;
   int mismatches     = 0;

   // idling control: random idle bursts on both sides, with a density picked by idle_tick
   int       send_gap      = 0;
   int       stall_left    = 0;
   int       hold_left     = 0;
   bit       held_once     = 1'b0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   logic [6:0] idle_tick   = '0;
   bit       steady_tail   = 1'b0;

   // next window of the file that the random traffic fills in
   logic [OFFSET_BITS-1:0] window_base = '0;

   byte_range_coverage_tracker_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // merge one delivered range into the predicted table and return the status it gives
   function automatic rsp_type deliver_range(req_type item);
      logic [63:0]            lo, hi, a, b, sum;
      logic [OFFSET_BITS-1:0] merged_lo [MAX_RANGES+1];
      logic [OFFSET_BITS-1:0] merged_hi [MAX_RANGES+1];
      int                     n, i;
      bit                     placed, rejected, completed;
      rsp_type                r;
      n = 0;
      placed = 1'b0;
      rejected = 1'b0;
      completed = 1'b0;
      // zero length and anything after completion leave the state alone
      if (item.range_length != '0 && !file_done) begin
         lo = 64'(item.range_start);
         hi = lo + 64'(item.range_length) - 64'd1;
         if (hi >= (64'd1 << OFFSET_BITS)) begin
            // last byte lies past the offset width
            rejected = 1'b1;
         end else begin
            for (i = 0; i < span_count; i++) begin
               a = 64'(span_lo[i]);
               b = 64'(span_hi[i]);
               if (b + 64'd1 < lo) begin
                  // stored range wholly below, not touching
                  merged_lo[n] = a[OFFSET_BITS-1:0];
                  merged_hi[n] = b[OFFSET_BITS-1:0];
                  n++;
               end else if (hi + 64'd1 < a) begin
                  // stored range wholly above: the new range goes in first
                  if (!placed) begin
                     merged_lo[n] = lo[OFFSET_BITS-1:0];
                     merged_hi[n] = hi[OFFSET_BITS-1:0];
                     n++;
                     placed = 1'b1;
                  end
                  merged_lo[n] = a[OFFSET_BITS-1:0];
                  merged_hi[n] = b[OFFSET_BITS-1:0];
                  n++;
               end else begin
                  // overlapping or adjacent: absorb it
                  if (a < lo) lo = a;
                  if (b > hi) hi = b;
               end
            end
            if (!placed) begin
               merged_lo[n] = lo[OFFSET_BITS-1:0];
               merged_hi[n] = hi[OFFSET_BITS-1:0];
               n++;
            end
            if (n > MAX_RANGES) begin
               // table would overflow
               rejected = 1'b1;
            end else begin
               sum = '0;
               for (i = 0; i < n; i++) begin
                  span_lo[i] = merged_lo[i];
                  span_hi[i] = merged_hi[i];
                  sum += 64'(merged_hi[i]) - 64'(merged_lo[i]) + 64'd1;
               end
               span_count = n;
               bytes_covered = sum[COV_W-1:0];
               if (bytes_covered >= COV_W'(file_size_model)) begin
                  file_done = 1'b1;
                  completed = 1'b1;
               end
            end
         end
      end
      r.covered_bytes  = bytes_covered;
      r.is_complete    = file_done;
      r.just_completed = completed;
      r.ranges_held    = HELD_W'(span_count);
      r.dropped        = rejected;
      return r;
   endfunction

   // idle density for both sides: none, light or heavy, picked each time idle_tick wraps
   always @(posedge clock) begin
      idle_tick <= idle_tick + 7'd1;
      if (idle_tick == '0) begin
         send_idle_pct <= 30 * $urandom_range(0, 2);
         recv_idle_pct <= 30 * $urandom_range(0, 2);
      end
   end

   // driver: offers queued items, predicts each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_status.insert(expected_status.size(), deliver_range(req_data));
            accepted_total = accepted_total + 1;
         end
         // the channel is free when nothing is offered or the offer was just taken
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || delivery_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               req_valid <= 1'b1;
               req_data  <= delivery_queue.pop_front();
               if (!steady_tail && $urandom_range(0, 99) < send_idle_pct) begin
                  send_gap <= $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // monitor: checks every result against the oldest prediction and drives rsp_ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_status.size() == 0) begin
               $display("%0t: result with none expected: %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_data.covered_bytes !== want.covered_bytes) begin
                  $display("%0t: covered_bytes expected %0d got %0d", $time,
                           want.covered_bytes, rsp_data.covered_bytes);
                  mismatches++;
               end
               if (rsp_data.is_complete !== want.is_complete) begin
                  $display("%0t: is_complete expected %0b got %0b", $time,
                           want.is_complete, rsp_data.is_complete);
                  mismatches++;
               end
               if (rsp_data.just_completed !== want.just_completed) begin
                  $display("%0t: just_completed expected %0b got %0b", $time,
                           want.just_completed, rsp_data.just_completed);
                  mismatches++;
               end
               if (rsp_data.ranges_held !== want.ranges_held) begin
                  $display("%0t: ranges_held expected %0d got %0d", $time,
                           want.ranges_held, rsp_data.ranges_held);
                  mismatches++;
               end
               if (rsp_data.dropped !== want.dropped) begin
                  $display("%0t: dropped expected %0b got %0b", $time,
                           want.dropped, rsp_data.dropped);
                  mismatches++;
               end
            end
         end
         // one long hold-off so the input queue fills and req_ready drops
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!held_once && results_seen == 500) begin
            held_once <= 1'b1;
            hold_left <= 300;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!steady_tail && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 5);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_delivery(logic [START_W-1:0] start, logic [LEN_W-1:0] len);
      req_type item;
      item.range_start  = start;
      item.range_length = len;
      delivery_queue.insert(delivery_queue.size(), item);
      queued_total++;
   endtask

   // random traffic: each window gets scattered pieces, then one item that fills it,
   // so the window collapses into the range below it and the table stays usable;
   // some zero-length items and items at the top of the offset space are mixed in
   task automatic queue_windows(int target);
      int               made, pieces, j, pick;
      logic [LEN_W-1:0] wsize, off, len;
      logic [63:0]      rnd;
      made = 0;
      while (made < target) begin
         if ($urandom_range(0, 9) == 0) wsize = '1;
         else wsize = LEN_W'($urandom_range(16, 4096));
         pieces = $urandom_range(4, 40);
         for (j = 0; j < pieces; j++) begin
            rnd  = {$urandom, $urandom};
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               queue_delivery(rnd[START_W-1:0], '0);
            end else if (pick == 1) begin
               queue_delivery({17'h1ffff, rnd[30:0]}, '1);
            end else begin
               off = LEN_W'(rnd[31:0] % 32'(wsize));
               len = LEN_W'(rnd[63:32] % 32'(wsize - off)) + 1'b1;
               queue_delivery(window_base + START_W'(off), len);
               made++;
            end
         end
         queue_delivery(window_base, wsize);
         made++;
         window_base += START_W'(wsize);
      end
   endtask

   // every queued item accepted and every result seen; sampled off the active edge
   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_total != queued_total || expected_status.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_file_size(logic [FSIZE_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      file_size_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // file size still zero from reset: zero length and past-width items complete nothing
      queue_delivery('0, '0);
      queue_delivery('1, 31'd2);
      wait_drained();

      // largest file size: the file never completes during the main traffic
      write_file_size('1);
      queue_delivery(48'd100, 31'd10);
      queue_delivery(48'd110, 31'd5);                        // touches on the right
      queue_delivery(48'd90, 31'd10);                        // touches on the left
      queue_delivery('1, 31'd1);                             // last byte of offset space
      queue_delivery(48'hffff_8000_0001, '1);                // longest item ending at the top
      queue_delivery(48'hffff_8000_0002, '1);                // one byte past the top
      queue_delivery('0, '1);                                // longest item at offset zero
      // fourteen single bytes, odd ones landing between the even ones, fill the table
      for (k = 0; k < 14; k += 2) queue_delivery(48'h1_0000_0000 + 48'(4 * k), 31'd1);
      for (k = 1; k < 14; k += 2) queue_delivery(48'h1_0000_0000 + 48'(4 * k), 31'd1);
      queue_delivery(48'h2_0000_0000, 31'd1);                // no room left
      queue_delivery(48'h1_0000_0000, 31'd56);               // swallows all fourteen
      window_base = 48'h1_0000_0038;
      queue_windows(1700);
      wait_drained();

      // file size just above the present coverage: completion comes early in this phase
      write_file_size(bytes_covered[FSIZE_W-1:0] + FSIZE_W'($urandom_range(1, 16)));
      queue_windows(200);
      wait_drained();

      // zero file size after completion, no idling for the rest of the run
      steady_tail = 1'b1;
      write_file_size('0);
      queue_windows(100);
      wait_drained();

      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("PASS byte_range_coverage_tracker_top");
      end else begin
         $display("FAIL byte_range_coverage_tracker_top");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10000000;
      $display("FAIL byte_range_coverage_tracker_top");
      $finish;
   end

endmodule
